### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while the active-low reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Concurrent assertion that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/mp3ar_pkg.sv
// ----------------------------------------------------------------------------
// mp3ar_pkg
// Widths, coefficient tables, stage payload types and arithmetic helpers
// for the Layer III alias-reduction block.
// ----------------------------------------------------------------------------
package mp3ar_pkg;

    // Data widths
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 16;
    localparam int Q23_BITS    = 24;

    // Granule geometry
    localparam int GRANULE_LEN  = 576;
    localparam int SUBBAND_LEN  = 18;
    localparam int NUM_SUBBANDS = 32;
    localparam int BUTTERFLIES  = 8;

    localparam int POS_BITS = $clog2(GRANULE_LEN);
    localparam int K_BITS   = $clog2(SUBBAND_LEN);
    localparam int SB_BITS  = $clog2(NUM_SUBBANDS);
    localparam int BF_BITS  = $clog2(BUTTERFLIES);

    // Product and sum widths
    localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
    localparam int RND_SHIFT  = COEF_BITS - 1;
    localparam int RPROD_BITS = PROD_BITS - RND_SHIFT;
    localparam int SUM_BITS   = RPROD_BITS + 1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [RPROD_BITS-1:0]  t_rprod;
    typedef logic signed [SUM_BITS-1:0]    t_sum;
    typedef logic [POS_BITS-1:0]           t_pos;
    typedef logic [BF_BITS-1:0]            t_bf;
    typedef logic [Q23_BITS-1:0]           t_q23_tab [BUTTERFLIES];
    typedef t_coef                         t_coef_tab [BUTTERFLIES];

    // Butterfly coefficients as Q1.23 magnitudes
    localparam t_q23_tab CS_Q23 = '{
        24'd7193172, 24'd7396588, 24'd7966062, 24'd8248641,
        24'd8351009, 24'd8381566, 24'd8387762, 24'd8388551
    };
    localparam t_q23_tab CA_MAG_Q23 = '{
        24'd4315903, 24'd3957175, 24'd2628801, 24'd1525999,
        24'd793346,  24'd343644,  24'd119106,  24'd31038
    };

    // Q1.23 magnitude -> Q1.(COEF_BITS-1), round half up, saturate
    function automatic t_coef q23_to_coef(input logic [Q23_BITS-1:0] mag,
                                          input logic negate);
        logic [Q23_BITS:0] v;
        logic [Q23_BITS:0] lim;
        int                sh;
        sh  = Q23_BITS - COEF_BITS;
        v   = {1'b0, mag};
        if (sh > 0) begin
            v = (v + ((Q23_BITS + 1)'(1) << (sh - 1))) >> sh;
        end
        lim = ((Q23_BITS + 1)'(1) << (COEF_BITS - 1)) - (Q23_BITS + 1)'(1);
        if (v > lim) begin
            v = lim;
        end
        return negate ? -t_coef'(v[COEF_BITS-1:0]) : t_coef'(v[COEF_BITS-1:0]);
    endfunction

    function automatic t_coef_tab build_tab(input t_q23_tab mags, input logic negate);
        t_coef_tab tab;
        for (int i = 0; i < BUTTERFLIES; i++) begin
            tab[i] = q23_to_coef(mags[i], negate);
        end
        return tab;
    endfunction

    // cs is positive, ca carries its negative sign
    localparam t_coef_tab CS_TAB = build_tab(CS_Q23, 1'b0);
    localparam t_coef_tab CA_TAB = build_tab(CA_MAG_Q23, 1'b1);

    // Front stage -> multiply stage
    typedef struct packed {
        logic    pair;
        t_bf     bf;
        t_sample smp;
        t_sample lo;
        t_pos    idx;
        t_pos    lidx;
    } t_s1;

    // Multiply stage -> output stage (hi is the incoming sample)
    typedef struct packed {
        logic    pair;
        t_sample smp;
        t_rprod  lo_cs;
        t_rprod  hi_ca;
        t_rprod  hi_cs;
        t_rprod  lo_ca;
        t_pos    idx;
        t_pos    lidx;
    } t_s2;

endpackage

### sv/mp3ar_if.sv
// ----------------------------------------------------------------------------
// mp3ar_if
// Valid/ready channels carrying input samples and reduced result samples.
// ----------------------------------------------------------------------------
interface mp3ar_in_if;
    logic                 valid;
    logic                 ready;
    mp3ar_pkg::t_sample   sample_in;
    logic                 first_of_granule;

    modport source (output valid, sample_in, first_of_granule, input ready);
    modport sink   (input valid, sample_in, first_of_granule, output ready);
endinterface

interface mp3ar_out_if;
    logic                 valid;
    logic                 ready;
    mp3ar_pkg::t_sample   sample_out;
    mp3ar_pkg::t_pos      sample_index;
    logic                 last_of_run;

    modport source (output valid, sample_out, sample_index, last_of_run, input ready);
    modport sink   (input valid, sample_out, sample_index, last_of_run, output ready);
endinterface

### sv/mp3ar_front.sv
// ----------------------------------------------------------------------------
// mp3ar_front
// Position tracking, lower-sample store and the input register stage.
// ----------------------------------------------------------------------------
module mp3ar_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mp3ar_in_if.sink        i_in,
    output logic            o_s1_valid,
    input  logic            i_s1_ready,
    output mp3ar_pkg::t_s1  o_s1
);
    import mp3ar_pkg::*;

    t_pos              r_pos, cur_pos, n_pos;
    logic [K_BITS-1:0]  r_k, cur_k, n_k;
    logic [SB_BITS-1:0] r_sb, cur_sb, n_sb;
    t_sample           r_held [BUTTERFLIES];
    logic              r_s1_valid;
    t_s1               r_s1;
    logic              accept;
    logic              is_hold;
    logic              is_pair;
    t_bf               hold_wr;
    t_bf               bf_rd;

    assign i_in.ready = !r_s1_valid || i_s1_ready;
    assign accept     = i_in.valid && i_in.ready;

    // Current position (restart on first_of_granule) and its successor
    always_comb begin
        cur_pos = i_in.first_of_granule ? '0 : r_pos;
        cur_k   = i_in.first_of_granule ? '0 : r_k;
        cur_sb  = i_in.first_of_granule ? '0 : r_sb;

        is_hold = (cur_k >= K_BITS'(SUBBAND_LEN - BUTTERFLIES))
                  && (cur_sb != SB_BITS'(NUM_SUBBANDS - 1));
        is_pair = (cur_k < K_BITS'(BUTTERFLIES)) && (cur_sb != '0);
        hold_wr = BF_BITS'(K_BITS'(SUBBAND_LEN - 1) - cur_k);
        bf_rd   = cur_k[BF_BITS-1:0];

        n_pos = (cur_pos == POS_BITS'(GRANULE_LEN - 1)) ? '0 : cur_pos + POS_BITS'(1);
        if (cur_k == K_BITS'(SUBBAND_LEN - 1)) begin
            n_k  = '0;
            n_sb = (cur_sb == SB_BITS'(NUM_SUBBANDS - 1)) ? '0 : cur_sb + SB_BITS'(1);
        end else begin
            n_k  = cur_k + K_BITS'(1);
            n_sb = cur_sb;
        end
    end

    // Position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_k   <= '0;
            r_sb  <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
            r_k   <= n_k;
            r_sb  <= n_sb;
        end
    end

    // Stage valid: held samples produce nothing downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= accept && !is_hold;
        end
    end

    // Lower-sample store and stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (is_hold) begin
                r_held[hold_wr] <= i_in.sample_in;
            end
            r_s1.pair <= is_pair;
            r_s1.bf   <= bf_rd;
            r_s1.smp  <= i_in.sample_in;
            r_s1.lo   <= r_held[bf_rd];
            r_s1.idx  <= cur_pos;
            r_s1.lidx <= cur_pos - POS_BITS'(1) - POS_BITS'({cur_k, 1'b0});
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

### sv/mp3ar_bfly.sv
// ----------------------------------------------------------------------------
// mp3ar_bfly
// Butterfly multiply stage: four rounded products per paired sample.
// ----------------------------------------------------------------------------
module mp3ar_bfly (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s1_valid,
    output logic            o_s1_ready,
    input  mp3ar_pkg::t_s1  i_s1,
    output logic            o_s2_valid,
    input  logic            i_s2_ready,
    output mp3ar_pkg::t_s2  o_s2
);
    import mp3ar_pkg::*;

    logic  r_s2_valid;
    t_s2   r_s2;
    t_coef cs;
    t_coef ca;

    // sample * coef, rounded half up to the sample scale
    function automatic t_rprod mul_round(input t_sample s, input t_coef c);
        logic signed [PROD_BITS-1:0] p;
        p = PROD_BITS'(s) * PROD_BITS'(c);
        p = p + (PROD_BITS'(1) <<< (RND_SHIFT - 1));
        return t_rprod'(p[PROD_BITS-1:RND_SHIFT]);
    endfunction

    assign cs         = CS_TAB[i_s1.bf];
    assign ca         = CA_TAB[i_s1.bf];
    assign o_s1_ready = !r_s2_valid || i_s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (o_s1_ready) begin
            r_s2_valid <= i_s1_valid;
        end
    end

    // Products for both halves of the butterfly
    always_ff @(posedge i_clk) begin
        if (i_s1_valid && o_s1_ready) begin
            r_s2.pair  <= i_s1.pair;
            r_s2.smp   <= i_s1.smp;
            r_s2.lo_cs <= mul_round(i_s1.lo, cs);
            r_s2.hi_ca <= mul_round(i_s1.smp, ca);
            r_s2.hi_cs <= mul_round(i_s1.smp, cs);
            r_s2.lo_ca <= mul_round(i_s1.lo, ca);
            r_s2.idx   <= i_s1.idx;
            r_s2.lidx  <= i_s1.lidx;
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s2       = r_s2;

endmodule

### sv/mp3ar_outbuf.sv
// ----------------------------------------------------------------------------
// mp3ar_outbuf
// Butterfly sums with saturation and a two-entry result buffer.
// ----------------------------------------------------------------------------
module mp3ar_outbuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s2_valid,
    output logic            o_s2_ready,
    input  mp3ar_pkg::t_s2  i_s2,
    mp3ar_out_if.source     o_out
);
    import mp3ar_pkg::*;

    localparam t_sum SAT_HI = (SUM_BITS'(1) <<< (SAMPLE_BITS - 1)) - SUM_BITS'(1);
    localparam t_sum SAT_LO = -SAT_HI - SUM_BITS'(1);

    // Slot 0 holds the lower result of a pair, slot 1 the final result
    logic [1:0] r_cnt;
    t_sample    r_smp [2];
    t_pos       r_idx [2];
    logic       head;
    logic       pop;
    logic       take;
    logic       load;
    t_sum       lo_sum;
    t_sum       hi_sum;

    function automatic t_sample sat(input t_sum v);
        t_sum r;
        r = v;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end
        return t_sample'(r[SAMPLE_BITS-1:0]);
    endfunction

    assign lo_sum = SUM_BITS'(i_s2.lo_cs) - SUM_BITS'(i_s2.hi_ca);
    assign hi_sum = SUM_BITS'(i_s2.hi_cs) + SUM_BITS'(i_s2.lo_ca);

    // Buffer control: refill once the last held result leaves
    assign head       = (r_cnt != 2'd2);
    assign pop        = o_out.valid && o_out.ready;
    assign take       = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign load       = i_s2_valid && take;
    assign o_s2_ready = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (load) begin
            r_cnt <= i_s2.pair ? 2'd2 : 2'd1;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_smp[0] <= sat(lo_sum);
            r_idx[0] <= i_s2.lidx;
            r_smp[1] <= i_s2.pair ? sat(hi_sum) : i_s2.smp;
            r_idx[1] <= i_s2.idx;
        end
    end

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.sample_out   = r_smp[head];
    assign o_out.sample_index = r_idx[head];
    assign o_out.last_of_run  = head;

endmodule

### sv/mp3_alias_reduction_top.sv
// ----------------------------------------------------------------------------
// mp3_alias_reduction_top
// Layer III alias-reduction butterflies over one long-block granule.
// ----------------------------------------------------------------------------
// Usage:
//   i_in takes the 576 samples of a granule in natural order; set
//   first_of_granule on sample zero to resync the position counter.
//   o_out returns each result with its granule index. Lower samples of a
//   subband boundary (offsets 10..17) are held and return nothing; when the
//   partner sample arrives, two transactions go out, the lower result with
//   last_of_run low, then the upper one with last_of_run high. All other
//   samples pass through unchanged with last_of_run high.
// Timing:
//   Three register stages (input, product, result buffer). A result passes
//   through all three before it can be taken. Pass-through and held samples go
//   at one per cycle while o_out takes results; a paired sample holds the buffer
//   until the single output port has drained the lower result of the pair.
// Reset and stall:
//   Reset zeroes the position and empties every stage; held samples are
//   undefined until written. When o_out stalls, results stay in the buffer
//   and the stages behind it fill before i_in.ready drops.
// ----------------------------------------------------------------------------
module mp3_alias_reduction_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mp3ar_in_if.sink     i_in,
    mp3ar_out_if.source  o_out
);
    import mp3ar_pkg::*;

    logic s1_valid;
    logic s1_ready;
    t_s1  s1;
    logic s2_valid;
    logic s2_ready;
    t_s2  s2;

    mp3ar_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_s1_valid (s1_valid),
        .i_s1_ready (s1_ready),
        .o_s1       (s1)
    );

    mp3ar_bfly u_bfly (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .o_s1_ready (s1_ready),
        .i_s1       (s1),
        .o_s2_valid (s2_valid),
        .i_s2_ready (s2_ready),
        .o_s2       (s2)
    );

    mp3ar_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s2_valid (s2_valid),
        .o_s2_ready (s2_ready),
        .i_s2       (s2),
        .o_out      (o_out)
    );

endmodule

### sv/mp3ar_checker.sv
// ----------------------------------------------------------------------------
// mp3ar_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mp3ar_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input mp3ar_pkg::t_sample  i_out_sample,
    input mp3ar_pkg::t_pos     i_out_index,
    input logic                i_out_last
);

    // A stalled transaction keeps valid up
    `ASSERT_RST(a_valid_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result valid dropped while stalled")

    // A stalled transaction keeps its payload
    `ASSERT_RST(a_payload_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_sample) && $stable(i_out_index) && $stable(i_out_last), "result payload changed while stalled")

    // The upper half of a pair is valid right after the lower half and sits higher
    `ASSERT_RST(a_pair_follows, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last |=> i_out_valid && i_out_last && (i_out_index > $past(i_out_index)), "upper result of a pair missing or misplaced")

    // Reset empties the result buffer
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind mp3_alias_reduction_top mp3ar_checker u_mp3ar_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out),
    .i_out_index  (o_out.sample_index),
    .i_out_last   (o_out.last_of_run)
);

### verif/tb_mp3_alias_reduction_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mp3_alias_reduction_top
// Self-checking bench for the Layer III alias-reduction block: samples are
// streamed through the input channel, each accepted transaction is run
// through a behavioral butterfly predictor, and every result transaction is
// compared field by field with the oldest predicted sample.
// ----------------------------------------------------------------------------
module tb_mp3_alias_reduction_top;
    import mp3ar_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 8;
    // Longest correct quiet stretch is the longest send gap plus the longest
    // result stall plus the pipeline delay; this is many times that.
    localparam int QUIET_LIMIT   = 2000;
    localparam int LOWER_FIRST_K = SUBBAND_LEN - BUTTERFLIES;
    localparam int MAG_BITS      = 24;

    typedef struct {
        t_sample smp;
        t_pos    idx;
        logic    last;
    } t_reduced_sample;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mp3ar_in_if  in_ch ();
    mp3ar_out_if out_ch ();

    mp3_alias_reduction_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Predictor state
    t_reduced_sample expected_results [$];
    t_sample         held_lower [BUTTERFLIES];
    int              next_pos = 0;
    int              mismatch_count = 0;
    bit              idling_on = 1'b1;

    // Butterfly coefficient magnitudes, Q1.23
    function automatic int cs_mag(input int i);
        case (i)
            0: return 7193172;
            1: return 7396588;
            2: return 7966062;
            3: return 8248641;
            4: return 8351009;
            5: return 8381566;
            6: return 8387762;
            default: return 8388551;
        endcase
    endfunction

    function automatic int ca_mag(input int i);
        case (i)
            0: return 4315903;
            1: return 3957175;
            2: return 2628801;
            3: return 1525999;
            4: return 793346;
            5: return 343644;
            6: return 119106;
            default: return 31038;
        endcase
    endfunction

    // Q1.23 magnitude rounded half up to coefficient precision, saturated
    function automatic longint to_coef(input int mag);
        longint v;
        longint lim;
        v   = mag;
        lim = (64'sd1 <<< (COEF_BITS - 1)) - 1;
        if (COEF_BITS < MAG_BITS)
            v = (v + (64'sd1 <<< (MAG_BITS - COEF_BITS - 1))) >>> (MAG_BITS - COEF_BITS);
        return (v > lim) ? lim : v;
    endfunction

    // Product back to sample scale, ties toward +infinity
    function automatic longint round_product(input longint a, input longint b);
        return (a * b + (64'sd1 <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
    endfunction

    function automatic t_sample clamp_sample(input longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return t_sample'(v);
    endfunction

    // Advance the predictor by one accepted sample, queue what it produces
    task automatic reduce_alias(input t_sample s, input logic first);
        int              p;
        int              sb;
        int              k;
        longint          lo;
        longint          hi_in;
        longint          cs;
        longint          ca;
        t_reduced_sample r;
        p = first ? 0 : next_pos;
        if (p >= GRANULE_LEN) p = 0;
        next_pos = (p + 1 >= GRANULE_LEN) ? 0 : p + 1;
        sb = p / SUBBAND_LEN;
        k  = p % SUBBAND_LEN;
        if (k >= LOWER_FIRST_K && sb + 1 < NUM_SUBBANDS) begin
            // lower sample of a boundary: hold, nothing goes out
            held_lower[SUBBAND_LEN - 1 - k] = s;
        end else if (k < BUTTERFLIES && sb >= 1) begin
            lo    = held_lower[k];
            hi_in = s;
            cs    = to_coef(cs_mag(k));
            ca    = -to_coef(ca_mag(k));
            r.smp  = clamp_sample(round_product(lo, cs) - round_product(hi_in, ca));
            r.idx  = t_pos'(p - 1 - 2 * k);
            r.last = 1'b0;
            expected_results.push_back(r);
            r.smp  = clamp_sample(round_product(hi_in, cs) + round_product(lo, ca));
            r.idx  = t_pos'(p);
            r.last = 1'b1;
            expected_results.push_back(r);
        end else begin
            r.smp  = s;
            r.idx  = t_pos'(p);
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    // One input transaction, with an occasional idle burst ahead of it
    task automatic send_sample(input t_sample s, input logic first);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.sample_in        <= s;
        in_ch.first_of_granule <= first;
        do @(posedge i_clk); while (!in_ch.ready);
        reduce_alias(s, first);
    endtask

    // Mostly random samples, with the range ends mixed in
    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
            2: return '0;
            3: return '1;
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Range ends and alternating bit patterns at pass-through positions
    task automatic test_pass_extremes();
        send_sample({1'b0, {(SAMPLE_BITS - 1){1'b1}}}, 1'b1);
        send_sample({1'b1, {(SAMPLE_BITS - 1){1'b0}}}, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(t_sample'(1), 1'b0);
        send_sample(t_sample'(24'h555555), 1'b0);
        send_sample(t_sample'(24'hAAAAAA), 1'b0);
    endtask

    // Restart mid-granule, then drive all butterflies with full-scale
    // operands of every sign combination so sums saturate both ways
    task automatic test_extreme_pairs();
        t_sample max_s;
        t_sample min_s;
        t_sample s;
        max_s = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        min_s = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        for (int p = 0; p < SUBBAND_LEN + BUTTERFLIES; p++) begin
            if (p < SUBBAND_LEN)
                s = p[0] ? min_s : max_s;
            else
                s = p[1] ? min_s : max_s;
            send_sample(s, p == 0);
        end
    endtask

    // Granule stream: marker at sample zero on a coin flip (else the
    // counter wraps), and a rare restart in the middle of a granule
    task automatic test_granule_stream(input int n_items);
        logic first;
        for (int i = 0; i < n_items; i++) begin
            if (next_pos == 0)
                first = $urandom_range(0, 1);
            else
                first = ($urandom_range(0, 399) == 0);
            send_sample(pick_sample(), first);
        end
    endtask

    // Result side back-pressure in bursts, held off during reset
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_reduced_sample want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: sample_out %0d, sample_index %0d",
                       out_ch.sample_out, out_ch.sample_index);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_ch.sample_out !== want.smp) begin
                    $error("sample_out: expected %0d, actual %0d",
                           want.smp, out_ch.sample_out);
                    mismatch_count++;
                end
                if (out_ch.sample_index !== want.idx) begin
                    $error("sample_index: expected %0d, actual %0d",
                           want.idx, out_ch.sample_index);
                    mismatch_count++;
                end
                if (out_ch.last_of_run !== want.last) begin
                    $error("last_of_run: expected %0d, actual %0d",
                           want.last, out_ch.last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n                <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.sample_in        <= '0;
        in_ch.first_of_granule <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_pass_extremes();
        test_extreme_pairs();
        test_granule_stream(1150);
        // closing stretch runs at full rate on both sides unless the block holds off i_in
        idling_on = 1'b0;
        test_granule_stream(260);
        in_ch.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### mp3_alias_reduction_top.f
+incdir+sv
sv/mp3ar_pkg.sv
sv/mp3ar_if.sv
sv/mp3ar_front.sv
sv/mp3ar_bfly.sv
sv/mp3ar_outbuf.sv
sv/mp3_alias_reduction_top.sv
sv/mp3ar_checker.sv
verif/tb_mp3_alias_reduction_top.sv
